// ----- rtl/chs_pkg.sv -----
`timescale 1ns / 1ps
package chs_pkg;

  localparam int FRAC_BITS = 16;

  typedef logic signed [31:0] fx_t;
  typedef logic signed [63:0] fxw_t;

  localparam fx_t FX_MAX = 32'sh7fff_ffff;
  localparam fx_t FX_MIN = 32'sh8000_0000;

  // divider: quotient bits, numerator width after scaling, latency
  localparam int DIV_QB  = 32;
  localparam int DIV_NW  = 32 + FRAC_BITS;
  localparam int DIV_LAT = DIV_QB + 2;

  // square root: root bits, radicand width, latency
  localparam int SQ_RW  = (32 + FRAC_BITS) / 2;
  localparam int SQ_XW  = 2 * SQ_RW;
  localparam int SQ_LAT = SQ_RW;

  function automatic fxw_t fx_mul(input fx_t a, input fx_t b);
    fxw_t p;
    p = a * b;
    return p;
  endfunction

  // drop fraction bits of a full product: round magnitude, ties away from zero
  function automatic fx_t fx_round(input fxw_t p);
    logic        neg;
    logic [63:0] mag;
    logic [63:0] m2;
    fx_t         r;
    neg = p[63];
    mag = neg ? 64'(-p) : 64'(p);
    m2  = (mag + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
    if (m2 >= 64'h8000_0000) begin
      r = neg ? FX_MIN : FX_MAX;
    end else if (neg) begin
      r = -$signed(m2[31:0]);
    end else begin
      r = $signed(m2[31:0]);
    end
    return r;
  endfunction

  function automatic fx_t fx_sub(input fx_t a, input fx_t b);
    logic signed [32:0] d;
    fx_t                r;
    d = {a[31], a} - {b[31], b};
    if (d[32] != d[31]) begin
      r = d[32] ? FX_MIN : FX_MAX;
    end else begin
      r = d[31:0];
    end
    return r;
  endfunction

endpackage

// ----- rtl/chs_div.sv -----
`timescale 1ns / 1ps
module chs_div (
  input  logic          clk,
  input  logic          en,
  input  chs_pkg::fx_t  num,
  input  chs_pkg::fx_t  den,
  output chs_pkg::fx_t  quo
);
  import chs_pkg::*;

  typedef struct packed {
    logic [31:0] rem;
    logic [31:0] low;
    logic [31:0] q;
    logic [31:0] dm;
    logic        neg;
    logic        ovf;
    logic        dz;
    fx_t         zres;
  } dv_stg_t;

  dv_stg_t st_r   [DIV_QB + 1];
  dv_stg_t st_nxt [DIV_QB + 1];
  fx_t     quo_r;
  fx_t     quo_nxt;

  logic [31:0]       nm;
  logic [31:0]       dm;
  logic [DIV_NW-1:0] np;

  function automatic dv_stg_t dv_step(input dv_stg_t s);
    dv_stg_t     n;
    logic [32:0] r2;
    n  = s;
    r2 = {s.rem, s.low[31]};
    if (r2 >= {1'b0, s.dm}) begin
      n.rem = 32'(r2 - {1'b0, s.dm});
      n.q   = {s.q[30:0], 1'b1};
    end else begin
      n.rem = r2[31:0];
      n.q   = {s.q[30:0], 1'b0};
    end
    n.low = {s.low[30:0], 1'b0};
    return n;
  endfunction

  always_comb begin
    nm = num[31] ? 32'(-num) : 32'(num);
    dm = den[31] ? 32'(-den) : 32'(den);
    // add half the divisor up front so the floor quotient comes out rounded
    np = (DIV_NW'(nm) << FRAC_BITS) + DIV_NW'(dm >> 1);
    st_nxt[0].rem  = 32'(np[DIV_NW-1:32]);
    st_nxt[0].low  = np[31:0];
    st_nxt[0].q    = '0;
    st_nxt[0].dm   = dm;
    st_nxt[0].neg  = num[31] ^ den[31];
    st_nxt[0].ovf  = 32'(np[DIV_NW-1:32]) >= dm;
    st_nxt[0].dz   = (dm == 32'd0);
    st_nxt[0].zres = (nm == 32'd0) ? '0 : (num[31] ? FX_MIN : FX_MAX);
    for (int k = 1; k <= DIV_QB; k++) begin
      st_nxt[k] = dv_step(st_r[k-1]);
    end
  end

  always_comb begin
    if (st_r[DIV_QB].dz) begin
      quo_nxt = st_r[DIV_QB].zres;
    end else if (st_r[DIV_QB].neg) begin
      quo_nxt = (st_r[DIV_QB].ovf || st_r[DIV_QB].q[31]) ? FX_MIN
                                                         : -$signed(st_r[DIV_QB].q);
    end else begin
      quo_nxt = (st_r[DIV_QB].ovf || st_r[DIV_QB].q[31]) ? FX_MAX
                                                         : $signed(st_r[DIV_QB].q);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      st_r  <= st_nxt;
      quo_r <= quo_nxt;
    end
  end

  assign quo = quo_r;

endmodule

// ----- rtl/chs_sqrt.sv -----
`timescale 1ns / 1ps
module chs_sqrt (
  input  logic          clk,
  input  logic          en,
  input  chs_pkg::fx_t  v,
  output chs_pkg::fx_t  root
);
  import chs_pkg::*;

  typedef struct packed {
    logic [SQ_RW:0]   rem;
    logic [SQ_RW-1:0] q;
    logic [SQ_XW-1:0] xs;
  } sq_stg_t;

  sq_stg_t st_r   [SQ_RW];
  sq_stg_t st_nxt [SQ_RW];
  sq_stg_t init;

  // one root bit per stage from the top two radicand bits
  function automatic sq_stg_t sq_step(input sq_stg_t s);
    sq_stg_t          n;
    logic [SQ_RW+2:0] r2;
    logic [SQ_RW+2:0] tr;
    r2 = {s.rem, s.xs[SQ_XW-1 -: 2]};
    tr = {1'b0, s.q, 2'b01};
    if (r2 >= tr) begin
      n.rem = (SQ_RW + 1)'(r2 - tr);
      n.q   = {s.q[SQ_RW-2:0], 1'b1};
    end else begin
      n.rem = r2[SQ_RW:0];
      n.q   = {s.q[SQ_RW-2:0], 1'b0};
    end
    n.xs = {s.xs[SQ_XW-3:0], 2'b00};
    return n;
  endfunction

  always_comb begin
    init.rem = '0;
    init.q   = '0;
    init.xs  = v[31] ? '0 : (SQ_XW'(v[30:0]) << FRAC_BITS);
    st_nxt[0] = sq_step(init);
    for (int k = 1; k < SQ_RW; k++) begin
      st_nxt[k] = sq_step(st_r[k-1]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      st_r <= st_nxt;
    end
  end

  assign root = $signed(32'(st_r[SQ_RW-1].q));

endmodule

// ----- rtl/cholesky_spd3_solve.sv -----
// channel  direction  ports
// in       request    in_valid/in_ready, in_a11..in_a33, in_rhs1..in_rhs3
// out      result     out_valid/out_ready, out_sol1..out_sol3, out_solved
// cfg      write      cfg_valid/cfg_ready, cfg_data (pivot threshold)
//
// One request enters per clock while out_ready is high or the output stage is empty;
// results carry 16 fraction bits. Six dividers and three square roots
// lie in series, plus multiply, round and subtract stages between them.
// Synchronous active-low reset clears the valid bits and sets the threshold to 1.
// A stalled result freezes the whole pipeline; nothing is dropped or repeated.
`timescale 1ns / 1ps
module cholesky_spd3_solve (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  chs_pkg::fx_t  in_a11,
  input  chs_pkg::fx_t  in_a21,
  input  chs_pkg::fx_t  in_a31,
  input  chs_pkg::fx_t  in_a22,
  input  chs_pkg::fx_t  in_a32,
  input  chs_pkg::fx_t  in_a33,
  input  chs_pkg::fx_t  in_rhs1,
  input  chs_pkg::fx_t  in_rhs2,
  input  chs_pkg::fx_t  in_rhs3,
  output logic          out_valid,
  input  logic          out_ready,
  output chs_pkg::fx_t  out_sol1,
  output chs_pkg::fx_t  out_sol2,
  output chs_pkg::fx_t  out_sol3,
  output logic          out_solved,
  input  logic          cfg_valid,
  output logic          cfg_ready,
  input  logic [30:0]   cfg_data
);
  import chs_pkg::*;

  // stage map: a unit fed from stage i lands its result in stage i + LAT + 1
  localparam int P_L11 = SQ_LAT + 1;
  localparam int P_B   = P_L11 + DIV_LAT + 1;
  localparam int P_C1  = P_B + 1;
  localparam int P_C2  = P_B + 2;
  localparam int P_C3  = P_B + 3;
  localparam int P_L22 = P_C3 + SQ_LAT + 1;
  localparam int P_E   = P_L22 + DIV_LAT + 1;
  localparam int P_F1  = P_E + 1;
  localparam int P_F2  = P_E + 2;
  localparam int P_F3  = P_E + 3;
  localparam int P_L33 = P_F3 + SQ_LAT + 1;
  localparam int P_Y3  = P_L33 + DIV_LAT + 1;
  localparam int P_X3  = P_Y3 + DIV_LAT + 1;
  localparam int P_J1  = P_X3 + 1;
  localparam int P_J2  = P_X3 + 2;
  localparam int P_J3  = P_X3 + 3;
  localparam int P_X2  = P_J3 + DIV_LAT + 1;
  localparam int P_L1  = P_X2 + 1;
  localparam int P_L2  = P_X2 + 2;
  localparam int P_L3  = P_X2 + 3;
  localparam int P_L4  = P_X2 + 4;
  localparam int P_X1  = P_L4 + DIV_LAT + 1;
  localparam int P_OUT = P_X1 + 1;
  localparam int NSTG  = P_OUT + 1;

  typedef struct packed {
    fx_t  a11, a21, a31, a22, a32, a33, b1, b2, b3;
    fx_t  l11, l21, l31, y1, l22, l32, y2, l33, y3, x1, x2, x3;
    fx_t  t22, n32, n2, u33, u3, t33, w3, v2, z;
    fxw_t p1, p2, p3, p4, p5;
    fx_t  r1, r2, r3, r4, r5;
    logic ok;
  } ctx_t;

  ctx_t             pipe_r   [NSTG];
  ctx_t             pipe_nxt [NSTG];
  logic [NSTG-1:0]  vld_r;
  logic [NSTG-1:0]  vld_nxt;
  logic [30:0]      thr_r;
  logic [30:0]      thr_nxt;
  fx_t              thr_s;
  logic             en;

  fx_t sq_l11, sq_l22, sq_l33;
  fx_t dv_l21, dv_l31, dv_y1, dv_l32, dv_y2, dv_y3, dv_x3, dv_x2, dv_x1;

  assign en        = !vld_r[P_OUT] || out_ready;
  assign in_ready  = en;
  assign cfg_ready = 1'b1;
  assign thr_s     = $signed({1'b0, thr_r});

  chs_sqrt u_sq1 (.clk, .en, .v(pipe_r[0].a11),    .root(sq_l11));
  chs_sqrt u_sq2 (.clk, .en, .v(pipe_r[P_C3].t22), .root(sq_l22));
  chs_sqrt u_sq3 (.clk, .en, .v(pipe_r[P_F3].t33), .root(sq_l33));

  chs_div u_dv_l21 (.clk, .en, .num(pipe_r[P_L11].a21), .den(pipe_r[P_L11].l11), .quo(dv_l21));
  chs_div u_dv_l31 (.clk, .en, .num(pipe_r[P_L11].a31), .den(pipe_r[P_L11].l11), .quo(dv_l31));
  chs_div u_dv_y1  (.clk, .en, .num(pipe_r[P_L11].b1),  .den(pipe_r[P_L11].l11), .quo(dv_y1));
  chs_div u_dv_l32 (.clk, .en, .num(pipe_r[P_L22].n32), .den(pipe_r[P_L22].l22), .quo(dv_l32));
  chs_div u_dv_y2  (.clk, .en, .num(pipe_r[P_L22].n2),  .den(pipe_r[P_L22].l22), .quo(dv_y2));
  chs_div u_dv_y3  (.clk, .en, .num(pipe_r[P_L33].w3),  .den(pipe_r[P_L33].l33), .quo(dv_y3));
  chs_div u_dv_x3  (.clk, .en, .num(pipe_r[P_Y3].y3),   .den(pipe_r[P_Y3].l33),  .quo(dv_x3));
  chs_div u_dv_x2  (.clk, .en, .num(pipe_r[P_J3].v2),   .den(pipe_r[P_J3].l22),  .quo(dv_x2));
  chs_div u_dv_x1  (.clk, .en, .num(pipe_r[P_L4].z),    .den(pipe_r[P_L4].l11),  .quo(dv_x1));

  always_comb begin
    pipe_nxt[0]     = '0;
    pipe_nxt[0].a11 = in_a11;
    pipe_nxt[0].a21 = in_a21;
    pipe_nxt[0].a31 = in_a31;
    pipe_nxt[0].a22 = in_a22;
    pipe_nxt[0].a32 = in_a32;
    pipe_nxt[0].a33 = in_a33;
    pipe_nxt[0].b1  = in_rhs1;
    pipe_nxt[0].b2  = in_rhs2;
    pipe_nxt[0].b3  = in_rhs3;
    pipe_nxt[0].ok  = in_a11 > thr_s;
    for (int k = 1; k < NSTG; k++) begin
      pipe_nxt[k] = pipe_r[k-1];
    end

    pipe_nxt[P_L11].l11 = sq_l11;
    pipe_nxt[P_B].l21   = dv_l21;
    pipe_nxt[P_B].l31   = dv_l31;
    pipe_nxt[P_B].y1    = dv_y1;

    pipe_nxt[P_C1].p1 = fx_mul(pipe_r[P_B].l21, pipe_r[P_B].l21);
    pipe_nxt[P_C1].p2 = fx_mul(pipe_r[P_B].l31, pipe_r[P_B].l21);
    pipe_nxt[P_C1].p3 = fx_mul(pipe_r[P_B].l21, pipe_r[P_B].y1);
    pipe_nxt[P_C1].p4 = fx_mul(pipe_r[P_B].l31, pipe_r[P_B].l31);
    pipe_nxt[P_C1].p5 = fx_mul(pipe_r[P_B].l31, pipe_r[P_B].y1);
    pipe_nxt[P_C2].r1 = fx_round(pipe_r[P_C1].p1);
    pipe_nxt[P_C2].r2 = fx_round(pipe_r[P_C1].p2);
    pipe_nxt[P_C2].r3 = fx_round(pipe_r[P_C1].p3);
    pipe_nxt[P_C2].r4 = fx_round(pipe_r[P_C1].p4);
    pipe_nxt[P_C2].r5 = fx_round(pipe_r[P_C1].p5);
    pipe_nxt[P_C3].t22 = fx_sub(pipe_r[P_C2].a22, pipe_r[P_C2].r1);
    pipe_nxt[P_C3].n32 = fx_sub(pipe_r[P_C2].a32, pipe_r[P_C2].r2);
    pipe_nxt[P_C3].n2  = fx_sub(pipe_r[P_C2].b2,  pipe_r[P_C2].r3);
    pipe_nxt[P_C3].u33 = fx_sub(pipe_r[P_C2].a33, pipe_r[P_C2].r4);
    pipe_nxt[P_C3].u3  = fx_sub(pipe_r[P_C2].b3,  pipe_r[P_C2].r5);
    pipe_nxt[P_C3+1].ok = pipe_r[P_C3].ok && (pipe_r[P_C3].t22 > thr_s);

    pipe_nxt[P_L22].l22 = sq_l22;
    pipe_nxt[P_E].l32   = dv_l32;
    pipe_nxt[P_E].y2    = dv_y2;

    pipe_nxt[P_F1].p1  = fx_mul(pipe_r[P_E].l32, pipe_r[P_E].l32);
    pipe_nxt[P_F1].p2  = fx_mul(pipe_r[P_E].l32, pipe_r[P_E].y2);
    pipe_nxt[P_F2].r1  = fx_round(pipe_r[P_F1].p1);
    pipe_nxt[P_F2].r2  = fx_round(pipe_r[P_F1].p2);
    pipe_nxt[P_F3].t33 = fx_sub(pipe_r[P_F2].u33, pipe_r[P_F2].r1);
    pipe_nxt[P_F3].w3  = fx_sub(pipe_r[P_F2].u3,  pipe_r[P_F2].r2);
    pipe_nxt[P_F3+1].ok = pipe_r[P_F3].ok && (pipe_r[P_F3].t33 > thr_s);

    pipe_nxt[P_L33].l33 = sq_l33;
    pipe_nxt[P_Y3].y3   = dv_y3;
    pipe_nxt[P_X3].x3   = dv_x3;

    pipe_nxt[P_J1].p1 = fx_mul(pipe_r[P_X3].l32, pipe_r[P_X3].x3);
    pipe_nxt[P_J2].r1 = fx_round(pipe_r[P_J1].p1);
    pipe_nxt[P_J3].v2 = fx_sub(pipe_r[P_J2].y2, pipe_r[P_J2].r1);

    pipe_nxt[P_X2].x2 = dv_x2;

    pipe_nxt[P_L1].p1 = fx_mul(pipe_r[P_X2].l21, pipe_r[P_X2].x2);
    pipe_nxt[P_L1].p2 = fx_mul(pipe_r[P_X2].l31, pipe_r[P_X2].x3);
    pipe_nxt[P_L2].r1 = fx_round(pipe_r[P_L1].p1);
    pipe_nxt[P_L2].r2 = fx_round(pipe_r[P_L1].p2);
    pipe_nxt[P_L3].z  = fx_sub(pipe_r[P_L2].y1, pipe_r[P_L2].r1);
    pipe_nxt[P_L4].z  = fx_sub(pipe_r[P_L3].z,  pipe_r[P_L3].r2);

    pipe_nxt[P_X1].x1 = dv_x1;

    // zero the solution of a failed factorization
    pipe_nxt[P_OUT].x1 = pipe_r[P_X1].ok ? pipe_r[P_X1].x1 : '0;
    pipe_nxt[P_OUT].x2 = pipe_r[P_X1].ok ? pipe_r[P_X1].x2 : '0;
    pipe_nxt[P_OUT].x3 = pipe_r[P_X1].ok ? pipe_r[P_X1].x3 : '0;
  end

  always_comb begin
    vld_nxt = {vld_r[NSTG-2:0], in_valid};
    thr_nxt = cfg_valid ? cfg_data : thr_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pipe_r <= pipe_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
      thr_r <= 31'd1;
    end else begin
      if (en) begin
        vld_r <= vld_nxt;
      end
      thr_r <= thr_nxt;
    end
  end

  assign out_valid  = vld_r[P_OUT];
  assign out_sol1   = pipe_r[P_OUT].x1;
  assign out_sol2   = pipe_r[P_OUT].x2;
  assign out_sol3   = pipe_r[P_OUT].x3;
  assign out_solved = pipe_r[P_OUT].ok;

  a_enter: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> vld_r[0])
    else $error("accepted request did not enter the pipeline");

  a_freeze: assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> $stable(vld_r))
    else $error("pipeline moved while stalled");

  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_solved |-> out_sol1 == '0 && out_sol2 == '0 && out_sol3 == '0)
    else $error("failed solve returned a nonzero solution");

  a_cfg: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_valid && cfg_ready |=> thr_r == $past(cfg_data))
    else $error("threshold write lost");

endmodule

// ----- sim/chs_solve_checker.sv -----
`timescale 1ns / 1ps
module chs_solve_checker (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_valid,
  input  logic         in_ready,
  input  chs_pkg::fx_t in_a11,
  input  chs_pkg::fx_t in_a21,
  input  chs_pkg::fx_t in_a31,
  input  chs_pkg::fx_t in_a22,
  input  chs_pkg::fx_t in_a32,
  input  chs_pkg::fx_t in_a33,
  input  chs_pkg::fx_t in_rhs1,
  input  chs_pkg::fx_t in_rhs2,
  input  chs_pkg::fx_t in_rhs3,
  input  logic         out_valid,
  input  logic         out_ready,
  input  chs_pkg::fx_t out_sol1,
  input  chs_pkg::fx_t out_sol2,
  input  chs_pkg::fx_t out_sol3,
  input  logic         out_solved,
  input  logic         cfg_valid,
  input  logic         cfg_ready,
  input  logic [30:0]  cfg_data,
  output int           sol_errors,
  output int           sol_pending
);
  import chs_pkg::*;

  localparam longint S_MAX = 64'sd2147483647;
  localparam longint S_MIN = -64'sd2147483648;

  typedef struct {
    fx_t  x1;
    fx_t  x2;
    fx_t  x3;
    logic ok;
  } solution_t;

  solution_t   expected_q[$];
  longint      pivot_thr;

  function automatic longint sat(input longint v);
    if (v > S_MAX) return S_MAX;
    if (v < S_MIN) return S_MIN;
    return v;
  endfunction

  function automatic longint signed_mag(input longint mag, input bit neg);
    if (mag > 64'sd2147483648) mag = 64'sd2147483648;
    return neg ? -mag : sat(mag);
  endfunction

  function automatic longint qmul(input longint a, input longint b);
    longint p;
    longint mag;
    p   = a * b;
    mag = (p < 0) ? -p : p;
    mag = (mag + (64'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
    return signed_mag(mag, p < 0);
  endfunction

  function automatic longint qdiv(input longint n, input longint d);
    longint nm;
    longint dm;
    nm = (n < 0) ? -n : n;
    dm = (d < 0) ? -d : d;
    if (dm == 0) begin
      if (nm == 0) return 0;
      return (n < 0) ? S_MIN : S_MAX;
    end
    nm = nm <<< FRAC_BITS;
    return signed_mag((nm + dm / 2) / dm, (n < 0) != (d < 0));
  endfunction

  function automatic longint qsub(input longint a, input longint b);
    return sat(a - b);
  endfunction

  // bitwise integer root of v scaled up by the fraction bits
  function automatic longint qsqrt(input longint v);
    longint x;
    longint root;
    longint b;
    if (v <= 0) return 0;
    x    = v <<< FRAC_BITS;
    root = 0;
    b    = 64'sd1 <<< 62;
    while (b > x) b = b >>> 2;
    while (b != 0) begin
      if (x >= root + b) begin
        x    = x - (root + b);
        root = (root >>> 1) + b;
      end else begin
        root = root >>> 1;
      end
      b = b >>> 2;
    end
    return root;
  endfunction

  function automatic solution_t cholesky_solve(input longint a11, input longint a21,
      input longint a31, input longint a22, input longint a32, input longint a33,
      input longint b1, input longint b2, input longint b3, input longint thr);
    solution_t r;
    longint l11, l21, l31, l22, l32, l33, t22, t33;
    longint y1, y2, y3, x1, x2, x3;
    r = '{x1: '0, x2: '0, x3: '0, ok: 1'b0};
    if (a11 <= thr) return r;
    l11 = qsqrt(a11);
    l21 = qdiv(a21, l11);
    l31 = qdiv(a31, l11);
    t22 = qsub(a22, qmul(l21, l21));
    if (t22 <= thr) return r;
    l22 = qsqrt(t22);
    l32 = qdiv(qsub(a32, qmul(l31, l21)), l22);
    t33 = qsub(qsub(a33, qmul(l31, l31)), qmul(l32, l32));
    if (t33 <= thr) return r;
    l33 = qsqrt(t33);
    y1 = qdiv(b1, l11);
    y2 = qdiv(qsub(b2, qmul(l21, y1)), l22);
    y3 = qdiv(qsub(qsub(b3, qmul(l31, y1)), qmul(l32, y2)), l33);
    x3 = qdiv(y3, l33);
    x2 = qdiv(qsub(y2, qmul(l32, x3)), l22);
    x1 = qdiv(qsub(qsub(y1, qmul(l21, x2)), qmul(l31, x3)), l11);
    r.x1 = fx_t'(x1);
    r.x2 = fx_t'(x2);
    r.x3 = fx_t'(x3);
    r.ok = 1'b1;
    return r;
  endfunction

  task automatic report(input string field, input longint got, input longint exp);
    $display("%0t mismatch %s: got %0d expected %0d", $realtime, field, got, exp);
    sol_errors++;
  endtask

  always @(posedge clk) begin
    solution_t e;
    if (!rst_n) begin
      pivot_thr = 1;
      sol_errors = 0;
      expected_q.delete();
    end else begin
      if (cfg_valid && cfg_ready) pivot_thr = cfg_data;
      if (out_valid && out_ready) begin
        if (expected_q.size() == 0) begin
          $display("%0t result with no request outstanding", $realtime);
          sol_errors++;
        end else begin
          e = expected_q.pop_front();
          if (out_sol1 !== e.x1) report("sol1", out_sol1, e.x1);
          if (out_sol2 !== e.x2) report("sol2", out_sol2, e.x2);
          if (out_sol3 !== e.x3) report("sol3", out_sol3, e.x3);
          if (out_solved !== e.ok) report("solved", out_solved, e.ok);
        end
      end
      if (in_valid && in_ready)
        expected_q.push_back(cholesky_solve(in_a11, in_a21, in_a31, in_a22, in_a32,
                                            in_a33, in_rhs1, in_rhs2, in_rhs3, pivot_thr));
    end
    sol_pending = expected_q.size();
  end

endmodule

// ----- sim/tb_cholesky_spd3_solve.sv -----
`timescale 1ns / 1ps
module tb_cholesky_spd3_solve;
  import chs_pkg::*;

  localparam int IDLE_PCT   = 13;
  localparam int HOLD_LEN   = 1200;
  localparam int DRAIN_WAIT = 320;
  localparam int WDOG_LIMIT = 6000;
  localparam int HOLD_PHASE = 2;
  localparam int BUSY_PHASE = 5;
  localparam int NPHASE     = 6;

  typedef struct {
    fx_t a11, a21, a31, a22, a32, a33, b1, b2, b3;
  } spd_req_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  fx_t         in_a11 = '0, in_a21 = '0, in_a31 = '0, in_a22 = '0, in_a32 = '0;
  fx_t         in_a33 = '0, in_rhs1 = '0, in_rhs2 = '0, in_rhs3 = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  fx_t         out_sol1, out_sol2, out_sol3;
  logic        out_solved;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [30:0] cfg_data = '0;
  int          sol_errors;
  int          sol_pending;
  int          phase = 0;
  int          hold_left = 0;
  bit          held = 0;
  int          quiet_cycles = 0;

  cholesky_spd3_solve u_dut (.*);
  chs_solve_checker   u_chk (.*);

  initial begin
    forever #4 clk = ~clk;
  end

  // receiver: random stalls, one long hold-off, one phase always ready
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (phase == HOLD_PHASE && !held) begin
      out_ready <= 1'b0;
      hold_left <= HOLD_LEN;
      held      <= 1'b1;
    end else if (phase == BUSY_PHASE) begin
      out_ready <= 1'b1;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= IDLE_PCT);
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready) ||
        !rst_n) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WDOG_LIMIT) begin
      $display("FAILURE");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send(input spd_req_t r);
    if (phase != BUSY_PHASE && $urandom_range(0, 99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_a11 <= r.a11; in_a21 <= r.a21; in_a31 <= r.a31;
    in_a22 <= r.a22; in_a32 <= r.a32; in_a33 <= r.a33;
    in_rhs1 <= r.b1; in_rhs2 <= r.b2; in_rhs3 <= r.b3;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sol_pending != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  task automatic write_threshold(input logic [30:0] v);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic fx_t rnd32();
    return fx_t'($urandom());
  endfunction

  function automatic fx_t spread(input longint s);
    return fx_t'(longint'($urandom_range(0, s)) - s / 2);
  endfunction

  // mostly diagonally dominant matrices at a random scale, some noise, some broken
  function automatic spd_req_t random_request();
    spd_req_t r;
    longint   s;
    int       kind;
    kind = $urandom_range(0, 99);
    if (kind < 15) begin
      r = '{rnd32(), rnd32(), rnd32(), rnd32(), rnd32(), rnd32(), rnd32(), rnd32(), rnd32()};
      return r;
    end
    s = 64'sd1 <<< $urandom_range(8, 28);
    r.a11 = fx_t'(s + $urandom_range(0, 3 * s));
    r.a22 = fx_t'(s + $urandom_range(0, 3 * s));
    r.a33 = fx_t'(s + $urandom_range(0, 3 * s));
    r.a21 = spread(s);
    r.a31 = spread(s);
    r.a32 = spread(s);
    if ($urandom_range(0, 1)) begin
      r.b1 = rnd32(); r.b2 = rnd32(); r.b3 = rnd32();
    end else begin
      r.b1 = spread(s); r.b2 = spread(s); r.b3 = spread(s);
    end
    if (kind < 30) begin
      // break one pivot
      case ($urandom_range(0, 2))
        0: r.a11 = -r.a11;
        1: r.a22 = fx_t'($urandom_range(0, 65536));
        default: r.a33 = -r.a33;
      endcase
    end
    return r;
  endfunction

  localparam fx_t ONE  = 32'sh0001_0000;
  localparam fx_t A5   = 32'sh5555_5555;
  localparam fx_t AA   = 32'shAAAA_AAAA;

  spd_req_t       directed[$];
  logic [30:0]    thr_list[NPHASE];
  int             count_list[NPHASE];

  initial begin
    directed = '{
      '{ONE, 0, 0, ONE, 0, ONE, ONE, -ONE, 3 * ONE},
      '{0, 0, 0, 0, 0, 0, 0, 0, 0},
      '{FX_MAX, FX_MAX, FX_MAX, FX_MAX, FX_MAX, FX_MAX, FX_MAX, FX_MAX, FX_MAX},
      '{FX_MIN, FX_MIN, FX_MIN, FX_MIN, FX_MIN, FX_MIN, FX_MIN, FX_MIN, FX_MIN},
      '{1, 0, 0, ONE, 0, ONE, ONE, ONE, ONE},
      '{2, 0, 0, ONE, 0, ONE, ONE, ONE, ONE},
      '{2, 0, 0, 2, 0, 2, FX_MAX, FX_MIN, FX_MAX},
      '{ONE, ONE, 0, ONE, 0, ONE, ONE, ONE, ONE},
      '{ONE, 0, 0, ONE, 0, 0, ONE, ONE, ONE},
      '{ONE, 0, ONE, ONE, 0, ONE, ONE, ONE, ONE},
      '{-ONE, 0, 0, ONE, 0, ONE, ONE, ONE, ONE},
      '{ONE, 0, 0, -ONE, 0, ONE, ONE, ONE, ONE},
      '{FX_MAX, FX_MIN, FX_MAX, FX_MAX, FX_MIN, FX_MAX, FX_MIN, FX_MAX, FX_MIN},
      '{FX_MAX, 0, 0, FX_MAX, 0, FX_MAX, FX_MAX, FX_MIN, FX_MAX},
      '{4 * ONE, ONE, -ONE, 4 * ONE, ONE, 4 * ONE, A5, AA, A5},
      '{A5, AA, A5, A5, AA, A5, AA, A5, AA},
      '{AA, A5, AA, AA, A5, AA, A5, AA, A5},
      '{3, 1, 1, 3, 1, 3, FX_MAX, FX_MAX, FX_MAX},
      '{ONE, 32'sh0000_ffff, 0, ONE, 0, ONE, ONE, 0, 0}
    };
    thr_list   = '{31'd1, 31'd0, 31'd65536, 31'h7fff_ffff, 31'd0, 31'd1};
    count_list = '{4, 4, 300, 4, 4, 24};
    thr_list[4] = 31'($urandom_range(0, 32'h0100_0000));

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int p = 0; p < NPHASE; p++) begin
      if (p > 0) begin
        drain();
        write_threshold(thr_list[p]);
      end
      phase <= p;
      @(posedge clk);
      foreach (directed[i]) send(directed[i]);
      for (int n = 0; n < count_list[p]; n++) begin
        // pause once until the pipeline is empty
        if (p == 4 && n == count_list[p] / 2) drain();
        send(random_request());
      end
    end

    in_valid <= 1'b0;
    @(posedge clk);
    while (sol_pending != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (sol_errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/chs_pkg.sv
rtl/chs_div.sv
rtl/chs_sqrt.sv
rtl/cholesky_spd3_solve.sv
sim/chs_solve_checker.sv
sim/tb_cholesky_spd3_solve.sv
